@@ hdl/tevq_pkg.sv @@
// ----------------------------------------------------------------------------
// tevq_pkg - shared types for the timed event queue
// Queue sizing, request/result payloads, status codes and the cell controls.
// ----------------------------------------------------------------------------
package tevq_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int UNIT_ID_BITS = 8;
    localparam int TIME_BITS    = 63;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_DUE  = 2'd3
    } status_t;

    typedef enum logic {
        REQ_SCHEDULE = 1'b0,
        REQ_POP      = 1'b1
    } req_type_t;

    // Broadcast command to every cell
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_CMP  = 2'd1,
        CELL_INS  = 2'd2,
        CELL_POP  = 2'd3
    } cell_op_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [UNIT_ID_BITS-1:0] unit_id;
        logic [TIME_BITS-1:0]    event_time;
    } req_t;

    typedef struct packed {
        logic [UNIT_ID_BITS-1:0] popped_unit;
        status_t                 status;
        logic [TIME_BITS-1:0]    head_time;
        logic                    queue_empty;
    } rsp_t;

    typedef struct packed {
        logic                    valid;
        logic [TIME_BITS-1:0]    etime;
        logic [UNIT_ID_BITS-1:0] unit;
    } entry_t;

    typedef struct packed {
        cell_op_t                op;
        logic [TIME_BITS-1:0]    etime;
        logic [UNIT_ID_BITS-1:0] unit;
    } cell_ctrl_t;

endpackage

@@ hdl/tevq_cell.sv @@
// ----------------------------------------------------------------------------
// tevq_cell - one slot of the sorted event chain
// Holds one entry, compares it against the broadcast request and shifts
// towards either neighbour on insert or pop.
// ----------------------------------------------------------------------------
module tevq_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tevq_pkg::cell_ctrl_t ctrl,
    input  tevq_pkg::entry_t     left_entry,
    input  logic                 left_place,
    input  tevq_pkg::entry_t     right_entry,
    output tevq_pkg::entry_t     entry,
    output logic                 place,
    output logic                 match
);

    tevq_pkg::entry_t entry_reg, entry_next;
    logic             place_reg, place_next;
    logic             match_reg, match_next;

    // place: this slot sits at or after the insertion point (free, or time >= t)
    always_comb begin
        place_next = place_reg;
        match_next = match_reg;
        if (ctrl.op == tevq_pkg::CELL_CMP) begin
            place_next = !entry_reg.valid || (entry_reg.etime >= ctrl.etime);
            match_next = entry_reg.valid && (entry_reg.etime == ctrl.etime)
                         && (entry_reg.unit == ctrl.unit);
        end
    end

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            tevq_pkg::CELL_INS: begin
                if (left_place) begin
                    entry_next = left_entry;
                end else if (place_reg) begin
                    entry_next = '{valid: 1'b1, etime: ctrl.etime, unit: ctrl.unit};
                end
            end
            tevq_pkg::CELL_POP: begin
                entry_next = right_entry;
            end
            tevq_pkg::CELL_HOLD,
            tevq_pkg::CELL_CMP: begin
                entry_next = entry_reg;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Only the valid bit needs a reset; payload is ignored while invalid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.etime <= entry_next.etime;
        entry_reg.unit  <= entry_next.unit;
        place_reg       <= place_next;
        match_reg       <= match_next;
    end

    assign entry = entry_reg;
    assign place = place_reg;
    assign match = match_reg;

endmodule

@@ hdl/timed_event_queue.sv @@
// ----------------------------------------------------------------------------
// timed_event_queue - sorted queue of wake-up events
// Chain of cells kept in timestamp order, earliest event at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry requests. A schedule request inserts
//   (event_time, unit_id) ahead of every queued entry with an equal or later
//   time; a pair already queued is refused (duplicate), and a full queue
//   drops the request. A pop request removes the head only when its time
//   equals event_time, otherwise it reports nothing due.
//   m_valid/m_ready/m_payload return one result per request, with the head
//   time and empty flag after the operation.
//   Sequence: a new request is taken only once the last result has been
//   loaded into the output register. After acceptance the cells compare in
//   parallel (S_CMP, flags registered), the duplicate OR and the shift are
//   applied (S_UPD), and the result is loaded into the output register (S_DONE).
//   When the receiver stalls, the result waits in the output register; the
//   next request can still be accepted and processed, and it holds before
//   its own result load until the register is free.
//   Reset clears every cell's valid bit: the queue comes up empty, ready.
// ----------------------------------------------------------------------------
module timed_event_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tevq_pkg::req_t   s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output tevq_pkg::rsp_t   m_payload
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    tevq_pkg::req_t   req_reg;
    tevq_pkg::status_t status_reg, status_next;
    logic [tevq_pkg::UNIT_ID_BITS-1:0] popped_reg, popped_next;

    logic          m_valid_reg, m_valid_next;
    tevq_pkg::rsp_t m_payload_reg, m_payload_next;

    tevq_pkg::cell_ctrl_t ctrl;
    tevq_pkg::entry_t     entry_w [tevq_pkg::QUEUE_DEPTH];
    logic [tevq_pkg::QUEUE_DEPTH-1:0] place_w;
    logic [tevq_pkg::QUEUE_DEPTH-1:0] match_w;

    logic accept;
    logic out_free;
    logic dup_hit;
    logic full;
    logic head_due;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Cell flags were registered in the compare cycle
    assign dup_hit  = |match_w;
    assign full     = entry_w[tevq_pkg::QUEUE_DEPTH-1].valid;
    assign head_due = entry_w[0].valid && (entry_w[0].etime == req_reg.event_time);

    // Compare in the compare cycle; decide the operation in the update cycle
    always_comb begin
        ctrl.etime  = req_reg.event_time;
        ctrl.unit   = req_reg.unit_id;
        ctrl.op     = tevq_pkg::CELL_HOLD;
        status_next = status_reg;
        popped_next = popped_reg;
        unique case (state_reg)
            S_CMP: begin
                ctrl.op = tevq_pkg::CELL_CMP;
            end
            S_UPD: begin
                popped_next = '0;
                if (req_reg.req_type == tevq_pkg::REQ_SCHEDULE) begin
                    priority if (dup_hit) begin
                        status_next = tevq_pkg::ST_DUP;
                    end else if (full) begin
                        status_next = tevq_pkg::ST_FULL;
                    end else begin
                        status_next = tevq_pkg::ST_OK;
                        ctrl.op     = tevq_pkg::CELL_INS;
                    end
                end else begin
                    if (head_due) begin
                        status_next = tevq_pkg::ST_OK;
                        popped_next = entry_w[0].unit;
                        ctrl.op     = tevq_pkg::CELL_POP;
                    end else begin
                        status_next = tevq_pkg::ST_NOT_DUE;
                    end
                end
            end
            S_IDLE,
            S_DONE: begin
                ctrl.op = tevq_pkg::CELL_HOLD;
            end
            default: begin
                ctrl.op = tevq_pkg::CELL_HOLD;
            end
        endcase
    end

    // Sequencer and output register
    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.popped_unit = popped_reg;
                    m_payload_next.status      = status_reg;
                    m_payload_next.head_time   = entry_w[0].valid ? entry_w[0].etime : '0;
                    m_payload_next.queue_empty = !entry_w[0].valid;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_payload;
        end
        status_reg    <= status_next;
        popped_reg    <= popped_next;
        m_payload_reg <= m_payload_next;
    end

    // Cell chain: cell 0 is the head
    genvar gi;
    generate
        for (gi = 0; gi < tevq_pkg::QUEUE_DEPTH; gi++) begin : g_cell
            tevq_pkg::entry_t left_e;
            tevq_pkg::entry_t right_e;
            logic             left_p;

            if (gi == 0) begin : g_head
                assign left_e = '0;
                assign left_p = 1'b0;
            end else begin : g_body
                assign left_e = entry_w[gi-1];
                assign left_p = place_w[gi-1];
            end

            if (gi == tevq_pkg::QUEUE_DEPTH-1) begin : g_tail
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = entry_w[gi+1];
            end

            tevq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_entry  (left_e),
                .left_place  (left_p),
                .right_entry (right_e),
                .entry       (entry_w[gi]),
                .place       (place_w[gi]),
                .match       (match_w[gi])
            );
        end
    endgenerate

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

@@ hdl/tevq_checker.sv @@
// ----------------------------------------------------------------------------
// tevq_checker - port-level checks for the timed event queue
// Result hold under stall, result field consistency, one request in flight.
// ----------------------------------------------------------------------------
module tevq_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input tevq_pkg::rsp_t m_payload
);

    // Stalled result stays put
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Empty queue reports a zero head time
    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.queue_empty |-> m_payload.head_time == '0)
        else $error("head time not zero on empty queue");

    // Nothing popped means no unit returned
    a_not_due_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == tevq_pkg::ST_NOT_DUE)
        |-> m_payload.popped_unit == '0)
        else $error("unit returned with nothing due");

    // A refused or dropped schedule implies queued entries
    a_refuse_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_payload.status == tevq_pkg::ST_DUP)
                 || (m_payload.status == tevq_pkg::ST_FULL))
        |-> !m_payload.queue_empty)
        else $error("duplicate or full reported on empty queue");

    // Busy straight after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready while a request is in flight");

endmodule

bind timed_event_queue tevq_checker u_tevq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
